FILE: hdl/tam_pkg.sv
`default_nettype none

package tam_pkg;

  localparam int unsigned COMPONENT_BITS_DEF = 16;
  localparam int unsigned FRACTION_BITS_DEF  = 14;

  // output field width and item counts
  localparam int unsigned DCM_W      = 16;
  localparam int unsigned DCM_ENTRY  = 9;
  localparam int unsigned IN_COMPS   = 12;
  localparam int unsigned FQ_DEPTH   = 2;

  // queue status seen by the back end
  typedef struct packed {
    logic avail;
    logic zero_vec;
    logic full;
  } fq_stat_t;

  // register stages in one normalizing unit: square, divide, root, round
  function automatic int unsigned unit_lat(input int unsigned f);
    return 3 * f + 7;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/triad_attitude_matrix_top.sv
// Path: from input transfer through two normalizing units in series to the result;
// FRACTION_BITS defaults to 14.
// Throughput: one item per cycle; every stage is registered and the whole back
// pipeline advances together, halting only while the output register is held.
// Reset: asynchronous, active low; clears queue pointers and all valid bits.
`default_nettype none

module triad_attitude_matrix_top #(
  parameter int unsigned COMPONENT_BITS = tam_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned FRACTION_BITS  = tam_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // body_a_x, body_a_y, body_a_z, body_b_x, body_b_y, body_b_z,
  // ref_a_x, ref_a_y, ref_a_z, ref_b_x, ref_b_y, ref_b_z, zero fill
  input  wire logic [((12*COMPONENT_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // dcm_r0c0, dcm_r0c1, dcm_r0c2, dcm_r1c0, dcm_r1c1, dcm_r1c2,
  // dcm_r2c0, dcm_r2c1, dcm_r2c2
  output logic [143:0]                                   m_axis_tdata,
  // degenerate
  output logic                                           m_axis_tuser
);
  import tam_pkg::*;

  localparam int unsigned IN_W = IN_COMPS * COMPONENT_BITS;

  fq_stat_t        fq_stat;
  logic [IN_W-1:0] fq_data;
  logic            fq_pop;

  tam_front #(.CB(COMPONENT_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[IN_W-1:0]),
    .pop_i      (fq_pop),
    .out_data_o (fq_data),
    .stat_o     (fq_stat)
  );

  tam_back #(.CB(COMPONENT_BITS), .F(FRACTION_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fq_stat_i (fq_stat),
    .fq_data_i (fq_data),
    .pop_o     (fq_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_deg_o   (m_axis_tuser)
  );

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result carries nonzero matrix");

  a_push_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> fq_stat.avail)
    else $error("accepted transfer missing from input queue");

endmodule

`default_nettype wire

FILE: hdl/tam_front.sv
`default_nettype none

module tam_front #(
  parameter int unsigned CB = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [12*CB-1:0]       in_data_i,
  input  wire logic                   pop_i,
  output logic [12*CB-1:0]            out_data_o,
  output tam_pkg::fq_stat_t           stat_o
);
  import tam_pkg::*;

  localparam int unsigned IN_W = IN_COMPS * CB;
  localparam int unsigned PW   = $clog2(FQ_DEPTH);
  localparam int unsigned CNTW = $clog2(FQ_DEPTH + 1);

  logic [IN_W-1:0] data_q [FQ_DEPTH];
  logic            zero_q [FQ_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            push, pop, zero_c;

  // flag any of the four vectors that is all zero
  always_comb begin
    zero_c = 1'b0;
    for (int v = 0; v < 4; v++) begin
      if (in_data_i[v*3*CB +: 3*CB] == '0) zero_c = 1'b1;
    end
  end

  assign in_ready_o = (cnt_q != CNTW'(FQ_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + CNTW'(1);
    if (pop && !push) cnt_d = cnt_q - CNTW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= in_data_i;
      zero_q[wr_ptr_q] <= zero_c;
    end
  end

  assign out_data_o     = data_q[rd_ptr_q];
  assign stat_o.avail    = (cnt_q != '0);
  assign stat_o.zero_vec = zero_q[rd_ptr_q];
  assign stat_o.full     = !in_ready_o;

endmodule

`default_nettype wire

FILE: hdl/tam_unit.sv
`default_nettype none

module tam_unit #(
  parameter int unsigned MAG_W = 16,
  parameter int unsigned SUM_W = 32,
  parameter int unsigned F     = 14
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic                    neg_i,
  input  wire logic [MAG_W-1:0]        mag_i,
  input  wire logic [SUM_W-1:0]        sum_i,
  output logic signed [F+1:0]          unit_o
);

  localparam int unsigned QW  = 2 * F + 3;
  localparam int unsigned RW  = F + 2;
  localparam int unsigned XW  = QW + 1;
  localparam int unsigned RMW = SUM_W + 1;

  logic [2*MAG_W-1:0] sq_c;
  logic [SUM_W-1:0]   m2_q, s0_q;
  logic               neg0_q;

  logic [SUM_W-1:0] rem_q [QW];
  logic [QW-1:0]    quo_q [QW];
  logic [SUM_W-1:0] dvs_q [QW-1];
  logic             dneg_q [QW];

  logic [XW-1:0] x_q [RW-1];
  logic [XW-1:0] r_q [RW];
  logic          sneg_q [RW];

  logic [XW-1:0]  half_c;
  logic [F+1:0]   uo_c;
  logic signed [F+1:0] unit_q;

  assign sq_c = (2*MAG_W)'(mag_i) * (2*MAG_W)'(mag_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m2_q   <= SUM_W'(sq_c);
      s0_q   <= sum_i;
      neg0_q <= neg_i;
    end
  end

  // restoring division of m^2 * 2^(2F+2) by the sum, one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [RMW-1:0]   trial;
    logic [SUM_W-1:0] div_s;
    logic             ge;
    if (i == 0) begin : g_first
      assign trial = {1'b0, m2_q};
      assign div_s = s0_q;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[i]  <= QW'(ge);
          dneg_q[i] <= neg0_q;
        end
      end
    end else begin : g_next
      assign trial = {rem_q[i-1], 1'b0};
      assign div_s = dvs_q[i-1];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[i]  <= {quo_q[i-1][QW-2:0], ge};
          dneg_q[i] <= dneg_q[i-1];
        end
      end
    end
    assign ge = (trial >= {1'b0, div_s});
    always_ff @(posedge clk_i) begin
      if (en_i) rem_q[i] <= ge ? SUM_W'(trial - {1'b0, div_s}) : SUM_W'(trial);
    end
    if (i < QW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) dvs_q[i] <= div_s;
      end
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam logic [XW-1:0] BIT = XW'(1) << (2 * (RW - 1 - j));
    logic [XW-1:0] x_in, r_in, t;
    logic          sg_in, ok;
    if (j == 0) begin : g_first
      assign x_in  = XW'(quo_q[QW-1]);
      assign r_in  = '0;
      assign sg_in = dneg_q[QW-1];
    end else begin : g_next
      assign x_in  = x_q[j-1];
      assign r_in  = r_q[j-1];
      assign sg_in = sneg_q[j-1];
    end
    assign t  = r_in + BIT;
    assign ok = (x_in >= t);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]    <= ok ? (r_in >> 1) + BIT : (r_in >> 1);
        sneg_q[j] <= sg_in;
      end
    end
    if (j < RW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) x_q[j] <= ok ? x_in - t : x_in;
      end
    end
  end

  // round half up, then apply sign
  assign half_c = (r_q[RW-1] + XW'(1)) >> 1;
  assign uo_c   = half_c[F+1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) unit_q <= sneg_q[RW-1] ? -$signed(uo_c) : $signed(uo_c);
  end

  assign unit_o = unit_q;

endmodule

`default_nettype wire

FILE: hdl/tam_back.sv
`default_nettype none

module tam_back #(
  parameter int unsigned CB = 16,
  parameter int unsigned F  = 14
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  tam_pkg::fq_stat_t                  fq_stat_i,
  input  wire logic [12*CB-1:0]              fq_data_i,
  output logic                               pop_o,
  output logic                               m_valid_o,
  input  wire logic                          m_ready_i,
  output logic [tam_pkg::DCM_W*9-1:0]        m_data_o,
  output logic                               m_deg_o
);
  import tam_pkg::*;

  localparam int unsigned UW   = F + 2;
  localparam int unsigned CW   = 2 * F + 3;
  localparam int unsigned MW2  = (2 * F + 2 > 31) ? 31 : 2 * F + 2;
  localparam int unsigned SW1  = 2 * CB;
  localparam int unsigned SW2  = 2 * MW2 + 2;
  localparam int unsigned T3W  = F + 3;
  localparam int unsigned AW   = 2 * F + 5;
  localparam int unsigned AXW  = AW + 2;
  localparam int unsigned KW   = $clog2(CW);
  localparam int unsigned LAT  = unit_lat(F);
  localparam logic [AXW-1:0] HALF = AXW'(1) << (F - 1);
  localparam logic signed [AXW-1:0] ONE = $signed(AXW'(1) << F);

  function automatic logic signed [AXW-1:0] rnd(input logic signed [AXW-1:0] x);
    logic [AXW-1:0] m, h;
    m   = x[AXW-1] ? $unsigned(-x) : $unsigned(x);
    h   = (m + HALF) >> F;
    rnd = x[AXW-1] ? -$signed(h) : $signed(h);
  endfunction

  logic en;

  // control
  logic v0_q, v1_q, v2_q, z0_q, z1_q, z2_q;
  logic dA_v_q [LAT];
  logic dA_z_q [LAT];
  logic v3_q, v4_q, v5_q, v6_q, v7_q, z3_q, z4_q, z5_q, z6_q, z7_q;
  logic dB_v_q [LAT];
  logic dB_z_q [LAT];
  logic v8_q, v9_q, v10_q, z8_q, z9_q, z10_q;
  logic out_v_q;

  // payload
  logic signed [CB-1:0] cmp0_q [12];
  logic [CB-1:0]        mag0_c [12];
  logic [SW1-1:0]       sq0_c  [12];
  logic [CB-1:0]        mag1_q [12], mag2_q [12];
  logic                 neg1_q [12], neg2_q [12];
  logic [SW1-1:0]       sq1_q  [12];
  logic [SW1-1:0]       sum2_q [4];
  logic signed [UW-1:0] na     [12];

  logic signed [2*UW-1:0] p3_q [2][6];
  logic signed [UW-1:0]   t1_3_q [2][3], t1_4_q [2][3], t1_5_q [2][3], t1_6_q [2][3],
                          t1_7_q [2][3];
  logic signed [CW-1:0]   c4_c [2][3], c4_q [2][3];
  logic                   cz4_c;
  logic [MW2-1:0]         mag5_c [2][3], mag5_q [2][3], mag6_q [2][3], mag7_q [2][3];
  logic                   neg5_q [2][3], neg6_q [2][3], neg7_q [2][3];
  logic [SW2-1:0]         sq6_q [2][3];
  logic [SW2-1:0]         sum7_q [2];
  logic signed [UW-1:0]   t2 [2][3];
  logic signed [UW-1:0]   dB_t1_q [LAT][2][3];

  logic signed [2*UW-1:0] p8_q [2][6];
  logic signed [UW-1:0]   t1_8_q [2][3], t2_8_q [2][3], t1_9_q [2][3], t2_9_q [2][3];
  logic signed [T3W-1:0]  t3_9_c [2][3], t3_9_q [2][3];
  logic signed [AW-1:0]   p10_q [3][3][3];
  logic [DCM_W*9-1:0]     out_c, out_q;

  assign en    = !out_v_q || m_ready_i;
  assign pop_o = en && fq_stat_i.avail;

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0;
      v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
      v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0; out_v_q <= 1'b0;
      for (int i = 0; i < LAT; i++) begin
        dA_v_q[i] <= 1'b0;
        dB_v_q[i] <= 1'b0;
      end
    end else if (en) begin
      v0_q <= fq_stat_i.avail;
      v1_q <= v0_q; v2_q <= v1_q;
      dA_v_q[0] <= v2_q;
      for (int i = 1; i < LAT; i++) dA_v_q[i] <= dA_v_q[i-1];
      v3_q <= dA_v_q[LAT-1];
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
      dB_v_q[0] <= v7_q;
      for (int i = 1; i < LAT; i++) dB_v_q[i] <= dB_v_q[i-1];
      v8_q <= dB_v_q[LAT-1];
      v9_q <= v8_q; v10_q <= v9_q;
      out_v_q <= v10_q;
    end
  end

  // degenerate flag rides with the payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      z0_q <= fq_stat_i.zero_vec;
      z1_q <= z0_q; z2_q <= z1_q;
      dA_z_q[0] <= z2_q;
      for (int i = 1; i < LAT; i++) dA_z_q[i] <= dA_z_q[i-1];
      z3_q <= dA_z_q[LAT-1];
      z4_q <= z3_q | cz4_c;
      z5_q <= z4_q; z6_q <= z5_q; z7_q <= z6_q;
      dB_z_q[0] <= z7_q;
      for (int i = 1; i < LAT; i++) dB_z_q[i] <= dB_z_q[i-1];
      z8_q <= dB_z_q[LAT-1];
      z9_q <= z8_q; z10_q <= z9_q;
    end
  end

  // input magnitudes and sums of squares
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      mag0_c[k] = cmp0_q[k][CB-1] ? $unsigned(-cmp0_q[k]) : $unsigned(cmp0_q[k]);
      sq0_c[k]  = SW1'(mag0_c[k]) * SW1'(mag0_c[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        cmp0_q[k] <= $signed(fq_data_i[k*CB +: CB]);
        mag1_q[k] <= mag0_c[k];
        neg1_q[k] <= cmp0_q[k][CB-1];
        sq1_q[k]  <= sq0_c[k];
        mag2_q[k] <= mag1_q[k];
        neg2_q[k] <= neg1_q[k];
      end
      for (int v = 0; v < 4; v++) begin
        sum2_q[v] <= sq1_q[3*v] + sq1_q[3*v+1] + sq1_q[3*v+2];
      end
    end
  end

  for (genvar k = 0; k < 12; k++) begin : g_unit_a
    tam_unit #(.MAG_W(CB), .SUM_W(SW1), .F(F)) u_unit (
      .clk_i  (clk_i),
      .en_i   (en),
      .neg_i  (neg2_q[k]),
      .mag_i  (mag2_q[k]),
      .sum_i  (sum2_q[k/3]),
      .unit_o (na[k])
    );
  end

  // second triad vector: cross of the unit vectors, scaled into range
  always_comb begin
    logic signed [2*UW:0] d;
    logic [CW-1:0]        mf;
    logic [CW-2:0]        mg [3];
    logic [CW-2:0]        mor;
    logic [KW-1:0]        sh;
    logic [CW-2:0]        ms;
    cz4_c = 1'b0;
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < 3; i++) begin
        d          = p3_q[f][2*i] - p3_q[f][2*i+1];
        c4_c[f][i] = $signed(d[CW-1:0]);
      end
      if (c4_c[f][0] == '0 && c4_c[f][1] == '0 && c4_c[f][2] == '0) cz4_c = 1'b1;
    end
    for (int f = 0; f < 2; f++) begin
      mor = '0;
      for (int i = 0; i < 3; i++) begin
        mf    = c4_q[f][i][CW-1] ? $unsigned(-c4_q[f][i]) : $unsigned(c4_q[f][i]);
        mg[i] = mf[CW-2:0];
        mor   = mor | mg[i];
      end
      // drop bits until every magnitude fits in 31 bits
      sh = '0;
      for (int j = 31; j < CW - 1; j++) begin
        if (mor[j]) sh = KW'(j - 30);
      end
      for (int i = 0; i < 3; i++) begin
        ms           = mg[i] >> sh;
        mag5_c[f][i] = ms[MW2-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int f = 0; f < 2; f++) begin
        p3_q[f][0] <= na[6*f+1] * na[6*f+5];
        p3_q[f][1] <= na[6*f+2] * na[6*f+4];
        p3_q[f][2] <= na[6*f+2] * na[6*f+3];
        p3_q[f][3] <= na[6*f+0] * na[6*f+5];
        p3_q[f][4] <= na[6*f+0] * na[6*f+4];
        p3_q[f][5] <= na[6*f+1] * na[6*f+3];
        for (int i = 0; i < 3; i++) begin
          t1_3_q[f][i] <= na[6*f+i];
          t1_4_q[f][i] <= t1_3_q[f][i];
          t1_5_q[f][i] <= t1_4_q[f][i];
          t1_6_q[f][i] <= t1_5_q[f][i];
          t1_7_q[f][i] <= t1_6_q[f][i];
          c4_q[f][i]   <= c4_c[f][i];
          mag5_q[f][i] <= mag5_c[f][i];
          neg5_q[f][i] <= c4_q[f][i][CW-1];
          mag6_q[f][i] <= mag5_q[f][i];
          neg6_q[f][i] <= neg5_q[f][i];
          sq6_q[f][i]  <= SW2'(mag5_q[f][i]) * SW2'(mag5_q[f][i]);
          mag7_q[f][i] <= mag6_q[f][i];
          neg7_q[f][i] <= neg6_q[f][i];
        end
        sum7_q[f] <= sq6_q[f][0] + sq6_q[f][1] + sq6_q[f][2];
      end
    end
  end

  for (genvar f = 0; f < 2; f++) begin : g_frame
    for (genvar i = 0; i < 3; i++) begin : g_unit_b
      tam_unit #(.MAG_W(MW2), .SUM_W(SW2), .F(F)) u_unit (
        .clk_i  (clk_i),
        .en_i   (en),
        .neg_i  (neg7_q[f][i]),
        .mag_i  (mag7_q[f][i]),
        .sum_i  (sum7_q[f]),
        .unit_o (t2[f][i])
      );
    end
  end

  // third triad vector, rounded back to F fraction bits
  always_comb begin
    logic signed [AW-1:0]  d;
    logic signed [AXW-1:0] r;
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < 3; i++) begin
        d            = p8_q[f][2*i] - p8_q[f][2*i+1];
        r            = rnd(AXW'(d));
        t3_9_c[f][i] = $signed(r[T3W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dB_t1_q[0] <= t1_7_q;
      for (int l = 1; l < LAT; l++) dB_t1_q[l] <= dB_t1_q[l-1];
      for (int f = 0; f < 2; f++) begin
        p8_q[f][0] <= dB_t1_q[LAT-1][f][1] * t2[f][2];
        p8_q[f][1] <= dB_t1_q[LAT-1][f][2] * t2[f][1];
        p8_q[f][2] <= dB_t1_q[LAT-1][f][2] * t2[f][0];
        p8_q[f][3] <= dB_t1_q[LAT-1][f][0] * t2[f][2];
        p8_q[f][4] <= dB_t1_q[LAT-1][f][0] * t2[f][1];
        p8_q[f][5] <= dB_t1_q[LAT-1][f][1] * t2[f][0];
        for (int i = 0; i < 3; i++) begin
          t1_8_q[f][i] <= dB_t1_q[LAT-1][f][i];
          t2_8_q[f][i] <= t2[f][i];
          t1_9_q[f][i] <= t1_8_q[f][i];
          t2_9_q[f][i] <= t2_8_q[f][i];
          t3_9_q[f][i] <= t3_9_c[f][i];
        end
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p10_q[r][c][0] <= t1_9_q[0][r] * t1_9_q[1][c];
          p10_q[r][c][1] <= t2_9_q[0][r] * t2_9_q[1][c];
          p10_q[r][c][2] <= t3_9_q[0][r] * t3_9_q[1][c];
        end
      end
    end
  end

  // matrix entries: sum, round, saturate to plus or minus one, zero if degenerate
  always_comb begin
    logic signed [AXW-1:0] acc, rv;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc = AXW'(p10_q[r][c][0]) + AXW'(p10_q[r][c][1]) + AXW'(p10_q[r][c][2]);
        rv  = rnd(acc);
        if (rv > ONE) rv = ONE;
        if (rv < -ONE) rv = -ONE;
        if (z10_q) rv = '0;
        out_c[(3*r+c)*DCM_W +: DCM_W] = rv[DCM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q   <= out_c;
      m_deg_o <= z10_q;
    end
  end

  assign m_valid_o = out_v_q;
  assign m_data_o  = out_q;

endmodule

`default_nettype wire
